FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

FILE: src/cesu_pkg.sv
`default_nettype none

package cesu_pkg;

  localparam int unsigned CESU_QUEUE_DEPTH = 4;

  // one decoded sequence: up to four output bytes, sent data[0] first
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      nbytes_m1;
    logic            last;
    logic            err;
  } cesu_cmd_t;

endpackage

`default_nettype wire

FILE: src/cesu_front.sv
`default_nettype none
`include "assert_macros.svh"

module cesu_front
  import cesu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic      in_last_i,
  output logic           emit_o,
  output cesu_cmd_t      cmd_o
);

  localparam logic [7:0]  ASCII_MAX = 8'h7F;
  localparam logic [7:0]  LEAD2_MAX = 8'hDF;
  localparam logic [7:0]  LEAD3_MAX = 8'hEF;
  localparam logic [7:0]  LEAD4     = 8'hF0;
  localparam logic [2:0]  LEN_NONE  = 3'd0;
  localparam logic [2:0]  LEN2      = 3'd2;
  localparam logic [2:0]  LEN3      = 3'd3;
  localparam logic [2:0]  LEN4      = 3'd4;
  localparam logic [2:0]  PAIR_LEN  = 3'd6;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  logic [7:0] held_q [5];
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] exp_q, exp_d;
  logic       pair_q, pair_d;
  logic       drop_q, drop_d;

  logic        held_we;
  logic [2:0]  held_wa;
  logic        fail, clr, emit;
  logic [2:0]  need;
  logic [9:0]  c1_lo, c2_lo;
  logic [20:0] cp;
  logic        hi_sur, lo_sur;
  cesu_cmd_t   cmd;

  always_comb begin
    drop_d  = drop_q;
    cnt_d   = cnt_q;
    exp_d   = exp_q;
    pair_d  = pair_q;
    held_we = 1'b0;
    held_wa = cnt_q;
    fail    = 1'b0;
    clr     = 1'b0;
    emit    = 1'b0;
    cmd     = '0;
    need    = pair_q ? PAIR_LEN : exp_q;
    c1_lo   = {held_q[1][3:0], held_q[2][5:0]};
    c2_lo   = {held_q[4][3:0], in_byte_i[5:0]};
    cp      = SUPP_BASE + {1'b0, c1_lo, c2_lo};
    hi_sur  = (held_q[0][3:0] == 4'hD) && (held_q[1][5:4] == 2'b10);
    lo_sur  = (held_q[3][3:0] == 4'hD) && (held_q[4][5:4] == 2'b11);

    if (drop_q) begin
      drop_d = !in_last_i;
    end else if (cnt_q == 3'd0) begin
      if (in_byte_i <= ASCII_MAX) begin
        emit          = 1'b1;
        cmd.data[0]   = in_byte_i;
        cmd.nbytes_m1 = 2'd0;
        cmd.last      = in_last_i;
      end else if (in_byte_i <= LEAD3_MAX || in_byte_i == LEAD4) begin
        if (in_byte_i <= LEAD2_MAX) begin
          exp_d = LEN2;
        end else if (in_byte_i <= LEAD3_MAX) begin
          exp_d = LEN3;
        end else begin
          exp_d = LEN4;
        end
        held_we = 1'b1;
        held_wa = 3'd0;
        cnt_d   = 3'd1;
        fail    = in_last_i;
      end else begin
        fail = 1'b1;
      end
    end else if (exp_q == LEN3 && cnt_q != 3'd3 && in_byte_i[7:6] != 2'b10) begin
      fail = 1'b1;
    end else if (cnt_q + 3'd1 < need) begin
      held_we = 1'b1;
      cnt_d   = cnt_q + 3'd1;
      fail    = in_last_i;
    end else begin
      unique case (exp_q)
        LEN2: begin
          emit          = 1'b1;
          cmd.data[0]   = held_q[0];
          cmd.data[1]   = in_byte_i;
          cmd.nbytes_m1 = 2'd1;
          cmd.last      = in_last_i;
          clr           = 1'b1;
        end
        LEN4: begin
          emit          = 1'b1;
          cmd.data[0]   = held_q[0];
          cmd.data[1]   = held_q[1];
          cmd.data[2]   = held_q[2];
          cmd.data[3]   = in_byte_i;
          cmd.nbytes_m1 = 2'd3;
          cmd.last      = in_last_i;
          clr           = 1'b1;
        end
        default: begin
          if (!pair_q) begin
            if (hi_sur) begin
              // high surrogate: keep it and wait for the low half
              pair_d  = 1'b1;
              held_we = 1'b1;
              held_wa = 3'd2;
              cnt_d   = 3'd3;
              fail    = in_last_i;
            end else begin
              emit          = 1'b1;
              cmd.data[0]   = held_q[0];
              cmd.data[1]   = held_q[1];
              cmd.data[2]   = in_byte_i;
              cmd.nbytes_m1 = 2'd2;
              cmd.last      = in_last_i;
              clr           = 1'b1;
            end
          end else if (!lo_sur) begin
            fail = 1'b1;
          end else begin
            emit          = 1'b1;
            cmd.data[0]   = {5'b11110, cp[20:18]};
            cmd.data[1]   = {2'b10, cp[17:12]};
            cmd.data[2]   = {2'b10, cp[11:6]};
            cmd.data[3]   = {2'b10, cp[5:0]};
            cmd.nbytes_m1 = 2'd3;
            cmd.last      = in_last_i;
            clr           = 1'b1;
          end
        end
      endcase
    end

    if (fail) begin
      clr           = 1'b1;
      drop_d        = !in_last_i;
      emit          = 1'b1;
      cmd           = '0;
      cmd.nbytes_m1 = 2'd0;
      cmd.last      = 1'b1;
      cmd.err       = 1'b1;
    end

    if (clr) begin
      cnt_d  = 3'd0;
      exp_d  = LEN_NONE;
      pair_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 3'd0;
      exp_q  <= LEN_NONE;
      pair_q <= 1'b0;
      drop_q <= 1'b0;
    end else if (accept_i) begin
      cnt_q  <= cnt_d;
      exp_q  <= exp_d;
      pair_q <= pair_d;
      drop_q <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && held_we) begin
      held_q[held_wa] <= in_byte_i;
    end
  end

  assign emit_o = accept_i && emit;
  assign cmd_o  = cmd;

  `ASSERT_ALWAYS(a_drop_no_seq, clk_i, rst_ni, drop_q |-> (cnt_q == 3'd0))
  `ASSERT_ALWAYS(a_pair_in_len3, clk_i, rst_ni, pair_q |-> (exp_q == LEN3 && cnt_q >= 3'd3))
  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= 3'd5)

endmodule

`default_nettype wire

FILE: src/cesu_fifo.sv
`default_nettype none
`include "assert_macros.svh"

module cesu_fifo
  import cesu_pkg::*;
#(
  parameter int unsigned Depth = CESU_QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cesu_cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cesu_cmd_t head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  cesu_cmd_t       mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   count_q;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    bump = (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full_o  = (count_q == CW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= bump(wr_q);
      end
      if (pop_i) begin
        rd_q <= bump(rd_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o)
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && !valid_o)
  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CW'(Depth))

endmodule

`default_nettype wire

FILE: src/cesu_back.sv
`default_nettype none

module cesu_back
  import cesu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  cesu_cmd_t cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [7:0] out_byte_o,
  output logic      out_last_o,
  output logic      error_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q, err_q;
  logic       adv, at_end;

  // output slot free and a sequence waiting
  assign adv    = cmd_valid_i && (!valid_q || out_ready_i);
  assign at_end = (idx_q == cmd_i.nbytes_m1);
  assign pop_o  = adv && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (adv) begin
      valid_q <= 1'b1;
      idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= cmd_i.data[idx_q];
      last_q <= cmd_i.last && at_end;
      err_q  <= cmd_i.err;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign error_o     = err_q;

endmodule

`default_nettype wire

FILE: src/cesu8_to_utf8_transcoder.sv
// one input byte per cycle while the decode queue has room; up to one output byte per cycle
// a sequence is decoded in the cycle its final byte is accepted; its first output byte
// is queued at that edge, then loaded into the output register when the slot is free
// a decode queue (QueueDepth entries) holds sequences of up to four output bytes each
// reset is asynchronous active low and clears sequence state, queue and output valid
`default_nettype none

module cesu8_to_utf8_transcoder
  import cesu_pkg::*;
#(
  parameter int unsigned QueueDepth = CESU_QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic            error_o
);

  logic      accept, emit, full, pop, cmd_valid;
  cesu_cmd_t cmd, head;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  cesu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .emit_o    (emit),
    .cmd_o     (cmd)
  );

  cesu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (emit),
    .push_cmd_i (cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (cmd_valid),
    .head_o     (head)
  );

  cesu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .error_o     (error_o)
  );

endmodule

`default_nettype wire

FILE: dv/tb_cesu8_to_utf8_transcoder.sv
`timescale 1ns / 1ps

module tb_cesu8_to_utf8_transcoder;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       err;
  } utf8_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;
  logic       error_o;

  // shadow of the decoder state
  logic [7:0] seq_buf [5];
  int         seq_cnt;
  int         seq_len;
  logic       pair_open;
  logic       skip_rest;

  utf8_byte_t utf8_expect_q [$];
  logic [7:0] str_q [$];
  int         live_items;
  int         fail_count;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_request;
  int         hold_left;

  cesu8_to_utf8_transcoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .error_o     (error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [15:0] cp3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return {a[3:0], b[5:0], c[5:0]};
  endfunction

  function automatic void push_utf8(logic [7:0] d, logic l, logic e);
    utf8_byte_t r;
    r.data = d;
    r.last = l;
    r.err  = e;
    utf8_expect_q.push_back(r);
  endfunction

  function automatic logic [7:0] rand_in(int lo, int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  task automatic predict_utf8(input logic [7:0] b, input logic l);
    int          pos;
    int          need;
    logic        fail;
    logic        done;
    logic [15:0] hi_cp;
    logic [15:0] lo_cp;
    logic [20:0] cp;
    fail = 1'b0;
    done = 1'b0;
    live_items++;
    if (skip_rest) begin
      if (l) skip_rest = 1'b0;
      return;
    end
    pos = seq_cnt;
    need = pair_open ? 6 : seq_len;
    if (pos == 0) begin
      if (b <= 8'h7F) begin
        push_utf8(b, l, 1'b0);
        return;
      end
      if (b <= 8'hDF) seq_len = 2;
      else if (b <= 8'hEF) seq_len = 3;
      else if (b == 8'hF0) seq_len = 4;
      else fail = 1'b1;
      if (!fail) begin
        seq_buf[0] = b;
        seq_cnt = 1;
        fail = l;
      end
    end else if (seq_len == 3 && pos != 3 && b[7:6] != 2'b10) begin
      fail = 1'b1;
    end else if (pos + 1 < need) begin
      seq_buf[pos] = b;
      seq_cnt = pos + 1;
      fail = l;
    end else if (seq_len == 2) begin
      push_utf8(seq_buf[0], 1'b0, 1'b0);
      push_utf8(b, l, 1'b0);
      done = 1'b1;
    end else if (seq_len == 4) begin
      push_utf8(seq_buf[0], 1'b0, 1'b0);
      push_utf8(seq_buf[1], 1'b0, 1'b0);
      push_utf8(seq_buf[2], 1'b0, 1'b0);
      push_utf8(b, l, 1'b0);
      done = 1'b1;
    end else if (!pair_open) begin
      hi_cp = cp3(seq_buf[0], seq_buf[1], b);
      if (hi_cp >= 16'hD800 && hi_cp <= 16'hDBFF) begin
        // high surrogate: hold it and wait for the low half
        pair_open = 1'b1;
        seq_buf[2] = b;
        seq_cnt = 3;
        fail = l;
      end else begin
        push_utf8(seq_buf[0], 1'b0, 1'b0);
        push_utf8(seq_buf[1], 1'b0, 1'b0);
        push_utf8(b, l, 1'b0);
        done = 1'b1;
      end
    end else begin
      hi_cp = cp3(seq_buf[0], seq_buf[1], seq_buf[2]);
      lo_cp = cp3(seq_buf[3], seq_buf[4], b);
      if (lo_cp < 16'hDC00 || lo_cp > 16'hDFFF) begin
        fail = 1'b1;
      end else begin
        cp = 21'h10000 + {1'b0, hi_cp[9:0], lo_cp[9:0]};
        push_utf8({5'b11110, cp[20:18]}, 1'b0, 1'b0);
        push_utf8({2'b10, cp[17:12]}, 1'b0, 1'b0);
        push_utf8({2'b10, cp[11:6]}, 1'b0, 1'b0);
        push_utf8({2'b10, cp[5:0]}, l, 1'b0);
        done = 1'b1;
      end
    end
    if (done || fail) begin
      seq_cnt = 0;
      seq_len = 0;
      pair_open = 1'b0;
    end
    if (fail) begin
      skip_rest = !l;
      push_utf8(8'h00, 1'b1, 1'b1);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= l;
    // ready is stable at the falling edge, the request goes at the next rising one
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    predict_utf8(b, l);
  endtask

  task automatic send_string();
    foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
    str_q.delete();
  endtask

  task automatic build_random_string();
    int kind;
    int cut;
    repeat ($urandom_range(5, 1)) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        str_q.push_back(rand_in(8'h00, 8'h7F));
      end else if (kind < 40) begin
        str_q.push_back(rand_in(8'h80, 8'hDF));
        str_q.push_back(rand_in(8'h00, 8'hFF));
      end else if (kind < 55) begin
        str_q.push_back(rand_in(8'hE0, 8'hEF));
        str_q.push_back(rand_in(8'h80, 8'hBF));
        str_q.push_back(rand_in(8'h80, 8'hBF));
      end else if (kind < 65) begin
        str_q.push_back(8'hF0);
        repeat (3) str_q.push_back(rand_in(8'h00, 8'hFF));
      end else if (kind < 88) begin
        // surrogate pair; the second lead only matters by its low nibble
        str_q.push_back(8'hED);
        str_q.push_back(rand_in(8'hA0, 8'hAF));
        str_q.push_back(rand_in(8'h80, 8'hBF));
        if ($urandom_range(3) == 0) str_q.push_back(rand_in(8'h00, 8'hFF));
        else str_q.push_back({4'($urandom_range(15)), 4'hD});
        if ($urandom_range(4) == 0) str_q.push_back(rand_in(8'h80, 8'hBF));
        else str_q.push_back(rand_in(8'hB0, 8'hBF));
        str_q.push_back(rand_in(8'h80, 8'hBF));
      end else begin
        str_q.push_back(rand_in(8'h00, 8'hFF));
      end
    end
    if ($urandom_range(99) < 15 && str_q.size() > 1) begin
      cut = $urandom_range(2, 1);
      while (cut > 0 && str_q.size() > 1) begin
        void'(str_q.pop_back());
        cut--;
      end
    end
  endtask

  task automatic run_random_strings(input int target);
    int start;
    start = live_items;
    while (live_items - start < target) begin
      build_random_string();
      send_string();
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (utf8_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
    // two-byte with unchecked continuation
    send_byte(8'hDF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);
    // surrogate pair, second lead taken by its low nibble only
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'hBD, 1'b0);
    send_byte(8'h3D, 1'b0);
    send_byte(8'hB8, 1'b0);
    send_byte(8'h80, 1'b1);
    // bad continuation, then the rest of the string is dropped
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hF1, 1'b1);
    // string ends inside a sequence
    send_byte(8'hC2, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int spct, input int rpct);
    send_idle_pct = spct;
    recv_stall_pct = rpct;
    run_random_strings(45);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 300;
    run_random_strings(40);
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk_i) begin : check_results
    utf8_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (utf8_expect_q.size() == 0) begin
        $error("unexpected result: out_byte %h out_last %b error %b",
               out_byte_o, out_last_o, error_o);
        fail_count++;
      end else begin
        want = utf8_expect_q.pop_front();
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_byte_o);
          fail_count++;
        end
        if (out_last_o !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, out_last_o);
          fail_count++;
        end
        if (error_o !== want.err) begin
          $error("error: expected %b, got %b", want.err, error_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    seq_cnt = 0;
    seq_len = 0;
    pair_open = 1'b0;
    skip_rest = 1'b0;
    live_items = 0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic(0, 0);
    test_random_traffic(75, 0);
    test_random_traffic(0, 75);
    test_random_traffic(24, 24);
    test_backpressure();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
